FILE: design/isbd_pkg.sv
// Shared types, constants and a helper function for the sample block decompressor.
// Used by every design module except isbd_checker; depends on nothing else.

package isbd_pkg;

  // Stream payload widths (fields packed from the lowest bit up).
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Bit buffer: a code is decoded as soon as it is complete, so at most
  // one bit less than the widest code plus the arriving bit is ever held.
  localparam int BUF_W  = 17;
  localparam int HELD_W = 5;

  // Per-mode constants.
  localparam logic [4:0]  FULL_W_8       = 5'd9;
  localparam logic [4:0]  FULL_W_16      = 5'd17;
  localparam logic [2:0]  SIZE_BITS_8    = 3'd3;
  localparam logic [2:0]  SIZE_BITS_16   = 3'd4;
  localparam logic [15:0] MAX_BLOCK_8    = 16'h8000;
  localparam logic [15:0] MAX_BLOCK_16   = 16'h4000;
  localparam logic [7:0]  UNSIGNED_BIAS  = 8'h80;
  localparam logic [4:0]  SHORT_W_LIMIT  = 5'd7;

  // Configuration register indexes.
  localparam int         CFG_IDX_W         = 1;
  localparam logic [0:0] REG_SIXTEEN_BIT   = 1'b0;
  localparam logic [0:0] REG_SOURCE_SIGNED = 1'b1;

  typedef struct packed {
    logic sixteen_bit;
    logic source_signed;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] sample_value;
    logic [15:0]       repeat_count;
    logic              last_of_block;
    logic              width_error;
  } result_t;

  typedef struct packed {
    logic load;
    logic shift;
  } ser_ctrl_t;

  typedef struct packed {
    logic       data_bit;
    logic [3:0] bits_left;
  } ser_stat_t;

  // Output byte of the accumulator for the current mode and source sign.
  function automatic logic [7:0] out_byte(input cfg_t cfg, input logic [15:0] acc);
    logic [7:0] b;
    b = cfg.sixteen_bit ? acc[15:8] : acc[7:0];
    if (!cfg.source_signed) begin
      b = b - UNSIGNED_BIAS;
    end
    return b;
  endfunction

endpackage

FILE: design/isbd_serializer.sv
// Byte serializer: holds the current compressed byte and hands it out one bit
// per cycle while the decoder shifts, least significant bit first. Depends on isbd_pkg.

module isbd_serializer import isbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ser_ctrl_t ctrl,
  input  logic [7:0] data_byte,
  output ser_stat_t stat
);

  logic [7:0] shift_r, shift_nxt;
  logic [3:0] left_r, left_nxt;

  always_comb begin
    shift_nxt = shift_r;
    left_nxt  = left_r;
    if (ctrl.load) begin
      shift_nxt = data_byte;
      left_nxt  = 4'd8;
    end else if (ctrl.shift) begin
      shift_nxt = shift_r >> 1;
      left_nxt  = left_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 4'd0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign stat.data_bit  = shift_r[0];
  assign stat.bits_left = left_r;

endmodule

FILE: design/isbd_decoder.sv
// Code decoder: collects bits, applies the three width-change rules,
// accumulates deltas and produces sample and fill results.
// Depends on isbd_pkg; drives isbd_serializer and feeds isbd_out_reg.

module isbd_decoder import isbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        block_start,
  input  logic [15:0] block_samples,
  input  logic        block_end,
  output ser_ctrl_t   ser_ctrl,
  input  ser_stat_t   ser_stat,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_free
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0]        state_r, state_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic [4:0]        cw_r, cw_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [15:0]       left_r, left_nxt;
  logic              halted_r, halted_nxt;
  logic              blk_end_r, blk_end_nxt;

  logic [4:0]        max_w;
  logic [2:0]        size_bits;
  logic [15:0]       cap, sat;
  logic              open_blk;
  logic [4:0]        w_eff;
  logic [BUF_W-1:0]  wmask, code, half, s_val, d_b;
  logic              neg, is_half, type_a, type_c;
  logic [4:0]        need_a, nw_a0, nw_a, nw_b0, nw_b;
  logic [3:0]        field, lo_b;
  logic [8:0]        nw_c;
  logic              illegal, cond_b, code_ready;
  logic [15:0]       v16, acc_sum;

  assign max_w     = cfg.sixteen_bit ? FULL_W_16 : FULL_W_8;
  assign size_bits = cfg.sixteen_bit ? SIZE_BITS_16 : SIZE_BITS_8;
  assign cap       = cfg.sixteen_bit ? MAX_BLOCK_16 : MAX_BLOCK_8;
  assign sat       = (block_samples > cap) ? cap : block_samples;
  assign open_blk  = block_start ? (sat != 16'd0) : ((left_r != 16'd0) && !halted_r);

  // A stored width of zero or above the mode's full width means full width.
  assign w_eff   = ((cw_r == 5'd0) || (cw_r > max_w)) ? max_w : cw_r;
  assign wmask   = BUF_W'((18'h1 << w_eff) - 18'd1);
  assign code    = buf_r & wmask;
  assign neg     = code[w_eff - 5'd1];
  assign half    = BUF_W'(18'h1 << (w_eff - 5'd1));
  assign is_half = (code == half);
  assign type_a  = (w_eff < SHORT_W_LIMIT);
  assign type_c  = (w_eff == max_w);

  // Short widths: the escape code is followed by a width field.
  assign need_a = w_eff + 5'(size_bits);
  assign field  = 4'(buf_r >> w_eff) & (cfg.sixteen_bit ? 4'hF : 4'h7);
  assign nw_a0  = {1'b0, field} + 5'd1;
  assign nw_a   = (nw_a0 >= w_eff) ? nw_a0 + 5'd1 : nw_a0;

  // Full width: a negative code carries the new width minus one in its low byte.
  assign nw_c    = {1'b0, code[7:0]} + 9'd1;
  assign illegal = (nw_c > {4'd0, max_w});

  // Middle widths: the codes just around the sign change select a width.
  assign s_val  = BUF_W'(1) << (size_bits - 3'd1);
  assign d_b    = (code + s_val - half) & wmask;
  assign cond_b = (d_b < (s_val << 1));
  assign lo_b   = code[3:0] + s_val[3:0];
  assign nw_b0  = {1'b0, lo_b} + 5'd1;
  assign nw_b   = (nw_b0 >= w_eff) ? nw_b0 + 5'd1 : nw_b0;

  assign code_ready = (type_a && is_half) ? (held_r >= need_a) : (held_r >= w_eff);

  // Delta reduced to 16 bits: sign-extend from the code width.
  assign v16     = code[15:0] | (neg ? ~wmask[15:0] : 16'h0);
  assign acc_sum = acc_r + v16;

  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    cw_nxt      = cw_r;
    buf_nxt     = buf_r;
    held_nxt    = held_r;
    left_nxt    = left_r;
    halted_nxt  = halted_r;
    blk_end_nxt = blk_end_r;
    in_ready    = (state_r == ST_IDLE);
    ser_ctrl    = '0;
    res_valid   = 1'b0;
    res         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (block_start) begin
            acc_nxt    = 16'd0;
            cw_nxt     = max_w;
            buf_nxt    = '0;
            held_nxt   = '0;
            left_nxt   = sat;
            halted_nxt = 1'b0;
          end
          if (open_blk) begin
            ser_ctrl.load = 1'b1;
            blk_end_nxt   = block_end;
            state_nxt     = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        cw_nxt = w_eff;
        if (code_ready) begin
          if (type_a && is_half) begin
            buf_nxt  = buf_r >> need_a;
            held_nxt = held_r - need_a;
            cw_nxt   = nw_a;
          end else if (type_c && neg) begin
            if (illegal) begin
              if (res_free) begin
                res_valid         = 1'b1;
                res.sample_value  = out_byte(cfg, acc_r);
                res.repeat_count  = left_r;
                res.last_of_block = 1'b1;
                res.width_error   = 1'b1;
                halted_nxt        = 1'b1;
                left_nxt          = 16'd0;
                buf_nxt           = '0;
                held_nxt          = '0;
                state_nxt         = ST_IDLE;
              end
            end else begin
              buf_nxt  = buf_r >> w_eff;
              held_nxt = held_r - w_eff;
              cw_nxt   = nw_c[4:0];
            end
          end else if (!type_a && !type_c && cond_b) begin
            buf_nxt  = buf_r >> w_eff;
            held_nxt = held_r - w_eff;
            cw_nxt   = nw_b;
          end else if (res_free) begin
            buf_nxt           = buf_r >> w_eff;
            held_nxt          = held_r - w_eff;
            acc_nxt           = acc_sum;
            left_nxt          = left_r - 16'd1;
            res_valid         = 1'b1;
            res.sample_value  = out_byte(cfg, acc_sum);
            res.repeat_count  = 16'd1;
            res.last_of_block = (left_r == 16'd1);
            res.width_error   = 1'b0;
            if (left_r == 16'd1) begin
              // Count reached: the rest of the byte and all held bits go.
              buf_nxt   = '0;
              held_nxt  = '0;
              state_nxt = ST_IDLE;
            end
          end
        end else if (ser_stat.bits_left != 4'd0) begin
          buf_nxt        = buf_r | (BUF_W'(ser_stat.data_bit) << held_r);
          held_nxt       = held_r + 5'd1;
          ser_ctrl.shift = 1'b1;
        end else if (blk_end_r) begin
          if (res_free) begin
            res_valid         = 1'b1;
            res.sample_value  = out_byte(cfg, acc_r);
            res.repeat_count  = left_r;
            res.last_of_block = 1'b1;
            res.width_error   = 1'b0;
            left_nxt          = 16'd0;
            buf_nxt           = '0;
            held_nxt          = '0;
            state_nxt         = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_r     <= 16'd0;
      cw_r      <= FULL_W_8;
      buf_r     <= '0;
      held_r    <= '0;
      left_r    <= 16'd0;
      halted_r  <= 1'b0;
      blk_end_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      cw_r      <= cw_nxt;
      buf_r     <= buf_nxt;
      held_r    <= held_nxt;
      left_r    <= left_nxt;
      halted_r  <= halted_nxt;
      blk_end_r <= blk_end_nxt;
    end
  end

endmodule

FILE: design/isbd_out_reg.sv
// Output register: holds one result until the downstream side takes it,
// and lets the decoder load the next one in the cycle of that transfer.
// Depends on isbd_pkg.

module isbd_out_reg import isbd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    res_free,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign res_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid && res_free) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: design/it_sample_block_decompressor_core.sv
// Top level of the compressed sample block decompressor: configuration
// registers, byte serializer, code decoder and output register.
// Depends on isbd_pkg, isbd_serializer, isbd_decoder and isbd_out_reg.
//
// Each input transfer carries one compressed byte; a transfer with the start
// flag opens a block of the given sample count (clamped to the mode's largest
// block). Bits enter the decoder one per cycle while no completed code waits,
// and every completed code or width change is handled in a step of its own. A
// byte of an open block is therefore taken, shifted in bit by bit with a step
// per completed code (at most eight), and ended by a closing step; a step that
// gives a result waits while the output side stalls. When the sample count is
// reached or an illegal width ends the block inside the byte, the remaining
// bits are not shifted in and no closing step follows.
// A byte outside an open block is taken and dropped.
// Each decoded sample leaves as one result with a repeat count of one; an
// early block end or an illegal full-width code leaves as one fill result
// that repeats the last value for the rest of the block.

module it_sample_block_decompressor_core import isbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // block_samples[15:0], data_byte[23:16]
  input  logic [0:0]           in_tuser,   // block_start[0]
  input  logic                 in_tlast,   // block_end
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // sample_value[7:0], repeat_count[23:8]
  output logic [0:0]           out_tuser,  // width_error[0]
  output logic                 out_tlast,  // last_of_block
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [0:0]           cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  ser_ctrl_t ser_ctrl;
  ser_stat_t ser_stat;
  logic      res_valid, res_free;
  result_t   res, out_res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SIXTEEN_BIT:   cfg_nxt.sixteen_bit   = cfg_wdata[0];
        REG_SOURCE_SIGNED: cfg_nxt.source_signed = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sixteen_bit   <= 1'b0;
      cfg_r.source_signed <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  isbd_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ser_ctrl),
    .data_byte (in_tdata[23:16]),
    .stat      (ser_stat)
  );

  isbd_decoder u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .block_start   (in_tuser[0]),
    .block_samples (in_tdata[15:0]),
    .block_end     (in_tlast),
    .ser_ctrl      (ser_ctrl),
    .ser_stat      (ser_stat),
    .res_valid     (res_valid),
    .res           (res),
    .res_free      (res_free)
  );

  isbd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {out_res.repeat_count, out_res.sample_value};
  assign out_tuser = out_res.width_error;
  assign out_tlast = out_res.last_of_block;

endmodule

FILE: design/isbd_checker.sv
// Port-level checks for the sample block decompressor and the bind that
// attaches them to the top level. Depends on it_sample_block_decompressor_core.

module isbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // A result held back by the sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result changed");

  // Opening a non-empty block keeps the input closed while its byte is decoded.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] && (in_tdata[15:0] != 16'd0) |=> !in_tready)
    else $error("input taken while a byte is being decoded");

  // A width error always ends the block.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("width error on a result that does not end the block");

  // Only a fill, which always ends the block, repeats a value.
  a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:8] != 16'd1) |-> out_tlast)
    else $error("repeated value before the end of the block");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind it_sample_block_decompressor_core isbd_checker u_isbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
